>>> hdl/ddmc_pkg.sv
// Shared types and constants for the differential drive mode controller.
// Used by ddmc_ctrl, ddmc_dp and the top level; depends on nothing.
package ddmc_pkg;

    // Event kinds on the input stream.
    typedef enum logic [1:0] {
        OP_REF      = 2'd0,
        OP_ENABLE   = 2'd1,
        OP_HALT_REL = 2'd2,
        OP_TICK     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_CONTROLLED = 2'd0,
        MODE_TIMEOUT    = 2'd1,
        MODE_HALT       = 2'd2
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] CfgPwmPeriod   = 2'd0;
    localparam logic [1:0] CfgTimeoutTick = 2'd1;
    localparam logic [1:0] CfgRpmLimit    = 2'd2;

    localparam logic [14:0] PwmPeriodReset   = 15'd1843;
    localparam logic [15:0] TimeoutTickReset = 16'd5000;
    localparam logic [12:0] RpmLimitReset    = 13'd5000;

    localparam int RefClamp   = 999;
    localparam int WheelGain  = 191;
    localparam int DutyOffset = 6000;
    localparam int DutyShift  = 42;
    // floor(2^42 / 6000); the quotient estimate is low by at most one.
    localparam logic [29:0] DutyRecip = 30'((64'd1 << DutyShift) / DutyOffset);

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic  load;
        logic  arm;
        logic  stop;
        mode_t stop_mode;
        logic  count;
        logic  wheel;
        logic  duty_mul;
        logic  duty_div;
        logic  out_load;
        logic  ack;
    } cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic halt;
        logic armed;
        logic expire;
    } stat_t;

endpackage

>>> hdl/ddmc_ctrl.sv
// Sequencer for the differential drive mode controller: decodes each event
// and steps the datapath through its stages. Depends on ddmc_pkg.
module ddmc_ctrl
    import ddmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  stat_t      stat,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WHEEL,
        S_MUL,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic   ack_reg, ack_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ack_next       = ack_reg;
        m_tvalid_next  = m_tvalid_reg;
        cmd            = '0;
        cmd.stop_mode  = MODE_HALT;
        cmd.ack        = ack_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = op_t'(s_tuser);
                    ack_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_MUL;
                unique case (op_reg)
                    OP_REF:
                    begin
                        if (!stat.halt)
                        begin
                            state_next = S_WHEEL;
                        end
                    end
                    OP_ENABLE:
                    begin
                        if (stat.halt)
                        begin
                            cmd.arm  = 1'b1;
                            ack_next = 1'b1;
                        end
                    end
                    OP_HALT_REL:
                    begin
                        cmd.stop      = 1'b1;
                        cmd.stop_mode = MODE_HALT;
                    end
                    OP_TICK:
                    begin
                        if (stat.armed)
                        begin
                            if (stat.expire)
                            begin
                                cmd.stop      = 1'b1;
                                cmd.stop_mode = MODE_TIMEOUT;
                            end
                            else
                            begin
                                cmd.count = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_MUL;
                    end
                endcase
            end
            S_WHEEL:
            begin
                cmd.wheel  = 1'b1;
                cmd.arm    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.duty_mul = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.duty_div = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                // Wait here until the output register is free.
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_REF;
            ack_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            ack_reg      <= ack_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

>>> hdl/ddmc_dp.sv
// Datapath of the differential drive mode controller: configuration, mode
// and speed state, wheel speed arithmetic, duty computation and the result
// register. Depends on ddmc_pkg.
module ddmc_dp
    import ddmc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic signed [15:0]  angular_ref,
    input  logic signed [15:0]  linear_ref,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic [1:0]          mode_now,
    output logic [15:0]         left_duty,
    output logic [15:0]         right_duty,
    output logic signed [13:0]  left_rpm_applied,
    output logic signed [13:0]  right_rpm_applied,
    output logic signed [16:0]  left_rpm_requested,
    output logic signed [16:0]  right_rpm_requested,
    output logic                alert_on,
    output logic                ack_enable
);

    function automatic logic signed [10:0] clamp_ref(input logic signed [15:0] v);
        if (v > 16'(RefClamp))
        begin
            return 11'(RefClamp);
        end
        else if (v < -16'(RefClamp))
        begin
            return -11'(RefClamp);
        end
        return v[10:0];
    endfunction

    // Configuration.
    logic [14:0] pwm_period_reg;
    logic [15:0] timeout_ticks_reg;
    logic [12:0] rpm_limit_reg;

    // Architectural state.
    mode_t              mode_reg, mode_next;
    logic               alert_reg, alert_next;
    logic [15:0]        counter_reg, counter_next;
    logic               armed_reg, armed_next;
    logic signed [13:0] applied_reg [2];
    logic signed [13:0] applied_next [2];
    logic signed [16:0] requested_reg [2];
    logic signed [16:0] requested_next [2];

    // Pipeline registers.
    logic signed [10:0] ang_reg, lin_reg;
    logic signed [21:0] prod_reg [2];
    logic signed [30:0] num_reg [2];
    logic [28:0]        numu_reg [2];
    logic               neg_reg [2];
    logic [16:0]        quot_reg [2];

    // Result register.
    logic [1:0]         mode_out_reg;
    logic [15:0]        duty_out_reg [2];
    logic signed [13:0] applied_out_reg [2];
    logic signed [16:0] requested_out_reg [2];
    logic               alert_out_reg;
    logic               ack_out_reg;

    logic [15:0]        counter_inc;
    logic signed [13:0] lin4;
    logic signed [13:0] wheel_sum [2];
    logic signed [21:0] prod_next [2];
    logic signed [21:0] rpm_full [2];
    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [14:0] duty_base [2];
    logic signed [30:0] num_next [2];
    logic [58:0]        recip_prod [2];
    logic [29:0]        remainder [2];
    logic [17:0]        quot_fix [2];
    logic [15:0]        duty_next [2];
    logic               sat_any;

    assign counter_inc = counter_reg + 16'd1;
    assign stat.halt   = (mode_reg == MODE_HALT);
    assign stat.armed  = armed_reg;
    assign stat.expire = (counter_inc >= timeout_ticks_reg);

    assign lin4         = 14'(lin_reg) <<< 2;
    assign wheel_sum[0] = lin4 + 14'(ang_reg);
    assign wheel_sum[1] = lin4 - 14'(ang_reg);
    assign lim_pos      = signed'(17'(rpm_limit_reg));
    assign lim_neg      = -lim_pos;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            prod_next[i] = 22'(wheel_sum[i]) * 22'(WheelGain);
            // Arithmetic shift gives the floor for negative products.
            rpm_full[i]  = prod_reg[i] >>> 4;
            duty_base[i] = 15'(applied_reg[i]) + 15'(DutyOffset);
            num_next[i]  = 31'(duty_base[i]) * signed'(31'(pwm_period_reg));
            recip_prod[i] = 59'(num_reg[i][28:0]) * 59'(DutyRecip);
            remainder[i] = 30'(numu_reg[i]) - 30'(quot_reg[i]) * 30'(DutyOffset);
            quot_fix[i]  = 18'(quot_reg[i]) + 18'(remainder[i] >= 30'(DutyOffset));
            if (neg_reg[i])
            begin
                duty_next[i] = 16'd0;
            end
            else if (quot_fix[i] > 18'hFFFF)
            begin
                duty_next[i] = 16'hFFFF;
            end
            else
            begin
                duty_next[i] = quot_fix[i][15:0];
            end
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        alert_next   = alert_reg;
        counter_next = counter_reg;
        armed_next   = armed_reg;
        sat_any      = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            applied_next[i]   = applied_reg[i];
            requested_next[i] = requested_reg[i];
        end
        if (cmd.wheel)
        begin
            for (int i = 0; i < 2; i++)
            begin
                requested_next[i] = rpm_full[i][16:0];
                if (signed'(rpm_full[i][16:0]) > lim_pos)
                begin
                    applied_next[i] = lim_pos[13:0];
                    sat_any         = 1'b1;
                end
                else if (signed'(rpm_full[i][16:0]) < lim_neg)
                begin
                    applied_next[i] = lim_neg[13:0];
                    sat_any         = 1'b1;
                end
                else
                begin
                    applied_next[i] = rpm_full[i][13:0];
                end
            end
            alert_next = sat_any;
        end
        if (cmd.arm)
        begin
            mode_next    = MODE_CONTROLLED;
            counter_next = 16'd0;
            armed_next   = 1'b1;
        end
        else if (cmd.stop)
        begin
            mode_next    = cmd.stop_mode;
            counter_next = 16'd0;
            armed_next   = 1'b0;
            alert_next   = 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                applied_next[i] = 14'sd0;
            end
        end
        else if (cmd.count)
        begin
            counter_next = counter_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg    <= PwmPeriodReset;
            timeout_ticks_reg <= TimeoutTickReset;
            rpm_limit_reg     <= RpmLimitReset;
            mode_reg          <= MODE_CONTROLLED;
            alert_reg         <= 1'b0;
            counter_reg       <= 16'd0;
            armed_reg         <= 1'b1;
            for (int i = 0; i < 2; i++)
            begin
                applied_reg[i]   <= 14'sd0;
                requested_reg[i] <= 17'sd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CfgPwmPeriod:   pwm_period_reg    <= cfg_wdata[14:0];
                    CfgTimeoutTick: timeout_ticks_reg <= cfg_wdata;
                    CfgRpmLimit:    rpm_limit_reg     <= cfg_wdata[12:0];
                    default:        pwm_period_reg    <= pwm_period_reg;
                endcase
            end
            mode_reg    <= mode_next;
            alert_reg   <= alert_next;
            counter_reg <= counter_next;
            armed_reg   <= armed_next;
            for (int i = 0; i < 2; i++)
            begin
                applied_reg[i]   <= applied_next[i];
                requested_reg[i] <= requested_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ang_reg <= clamp_ref(angular_ref);
            lin_reg <= clamp_ref(linear_ref);
        end
        for (int i = 0; i < 2; i++)
        begin
            prod_reg[i] <= prod_next[i];
            if (cmd.duty_mul)
            begin
                num_reg[i] <= num_next[i];
            end
            if (cmd.duty_div)
            begin
                neg_reg[i]  <= num_reg[i][30];
                numu_reg[i] <= num_reg[i][28:0];
                quot_reg[i] <= recip_prod[i][58:42];
            end
        end
        if (cmd.out_load)
        begin
            mode_out_reg  <= mode_reg;
            alert_out_reg <= alert_reg;
            ack_out_reg   <= cmd.ack;
            for (int i = 0; i < 2; i++)
            begin
                duty_out_reg[i]      <= duty_next[i];
                applied_out_reg[i]   <= applied_reg[i];
                requested_out_reg[i] <= requested_reg[i];
            end
        end
    end

    assign mode_now            = mode_out_reg;
    assign left_duty           = duty_out_reg[0];
    assign right_duty          = duty_out_reg[1];
    assign left_rpm_applied    = applied_out_reg[0];
    assign right_rpm_applied   = applied_out_reg[1];
    assign left_rpm_requested  = requested_out_reg[0];
    assign right_rpm_requested = requested_out_reg[1];
    assign alert_on            = alert_out_reg;
    assign ack_enable          = ack_out_reg;

endmodule

>>> hdl/differential_drive_mode_controller.sv
// Top level of the differential drive mode controller.
// Instantiates ddmc_ctrl and ddmc_dp; depends on ddmc_pkg.
//
// Input stream: one transfer per event. tuser carries the event kind
// (reference, enable, halt button released, 1 ms tick); tdata carries the
// angular and linear references, which only a reference event uses.
// Output stream: exactly one result transfer per event with the mode after
// the event, both duty compare values, applied and requested wheel speeds,
// the alert flag and the enable acknowledgement.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 PWM
// period, 1 timeout ticks, 2 rpm limit); write only while the block is idle.
// Each event passes the state update (a reference event also the wheel
// speed stage) and then the duty stages (product, reciprocal multiply,
// correction) before its result is valid. The sequencer handles one event
// at a time, so it accepts no new event before the current one is through.
// Reset: controlled mode, timeout counter armed, speeds zero, registers at
// their defaults (period 1843, timeout 5000, limit 5000).
// A stalled output holds its result; the next event may be accepted and
// processed meanwhile, and waits in its last stage until the result is taken.
module differential_drive_mode_controller
    import ddmc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // angular_ref[15:0], linear_ref[31:16]
    input  logic [1:0]   s_tuser,   // operation[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // mode_now[1:0], left_duty[17:2], right_duty[33:18],
    // left_rpm_applied[47:34], right_rpm_applied[61:48],
    // left_rpm_requested[78:62], right_rpm_requested[95:79],
    // alert_on[96], ack_enable[97], zero fill[103:98]
    output logic [103:0] m_tdata
);

    cmd_t               cmd;
    stat_t              stat;
    logic [1:0]         mode_now;
    logic [15:0]        left_duty;
    logic [15:0]        right_duty;
    logic signed [13:0] left_rpm_applied;
    logic signed [13:0] right_rpm_applied;
    logic signed [16:0] left_rpm_requested;
    logic signed [16:0] right_rpm_requested;
    logic               alert_on;
    logic               ack_enable;

    ddmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ddmc_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .angular_ref         (signed'(s_tdata[15:0])),
        .linear_ref          (signed'(s_tdata[31:16])),
        .cmd                 (cmd),
        .stat                (stat),
        .mode_now            (mode_now),
        .left_duty           (left_duty),
        .right_duty          (right_duty),
        .left_rpm_applied    (left_rpm_applied),
        .right_rpm_applied   (right_rpm_applied),
        .left_rpm_requested  (left_rpm_requested),
        .right_rpm_requested (right_rpm_requested),
        .alert_on            (alert_on),
        .ack_enable          (ack_enable)
    );

    assign m_tdata = {6'b0, ack_enable, alert_on,
                      right_rpm_requested, left_rpm_requested,
                      right_rpm_applied, left_rpm_applied,
                      right_duty, left_duty, mode_now};

endmodule

>>> dv/tb.sv
// Self-checking testbench for differential_drive_mode_controller: drives event streams
// and config writes, predicts each result in a scoreboard class and checks every output.
// Depends on ddmc_pkg and the RTL under hdl/.
module tb
    import ddmc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RefLimit      = 999;
    localparam int RpmPerUnit    = 191;
    localparam int DutyBase      = 6000;
    localparam int HoldOffCycles = 64;
    localparam int PhaseItems    = 125;

    typedef struct {
        mode_t              mode_now;
        logic [15:0]        left_duty;
        logic [15:0]        right_duty;
        logic signed [13:0] left_app;
        logic signed [13:0] right_app;
        logic signed [16:0] left_req;
        logic signed [16:0] right_req;
        logic               alert_on;
        logic               ack_enable;
    } drive_result_t;

    // Tracks the controller state, predicts one result per event and checks outputs.
    class drive_result_board;
        logic [14:0]   pwm_period;
        logic [15:0]   timeout_ticks;
        logic [12:0]   rpm_limit;
        mode_t         mode;
        logic          alert;
        logic [15:0]   tick_count;
        logic          armed;
        int            app_rpm[2];
        int            req_rpm[2];
        drive_result_t pending_drive_results[$];
        int            errors;

        function new();
            pwm_period    = PwmPeriodReset;
            timeout_ticks = TimeoutTickReset;
            rpm_limit     = RpmLimitReset;
            mode          = MODE_CONTROLLED;
            alert         = 1'b0;
            tick_count    = '0;
            armed         = 1'b1;
            app_rpm       = '{0, 0};
            req_rpm       = '{0, 0};
            errors        = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] value);
            case (idx)
                CfgPwmPeriod:   pwm_period = value[14:0];
                CfgTimeoutTick: timeout_ticks = value;
                CfgRpmLimit:    rpm_limit = value[12:0];
                default:        ;
            endcase
        endfunction

        function int clip_ref(logic signed [15:0] raw);
            int v;
            v = raw;
            if (v > RefLimit)
                return RefLimit;
            if (v < -RefLimit)
                return -RefLimit;
            return v;
        endfunction

        // Arithmetic shift of a signed product rounds toward minus infinity.
        function int rpm_of(int sum);
            return (sum * RpmPerUnit) >>> 4;
        endfunction

        function logic [15:0] duty_of(int rpm);
            longint num;
            num = (longint'(rpm) + DutyBase) * longint'(pwm_period);
            if (num < 0)
                return 16'd0;
            num = num / DutyBase;
            if (num > 65535)
                return 16'hFFFF;
            return 16'(num);
        endfunction

        function void park_wheels(mode_t next_mode);
            app_rpm    = '{0, 0};
            alert      = 1'b0;
            mode       = next_mode;
            tick_count = '0;
            armed      = 1'b0;
        endfunction

        function void note_event(op_t op, logic signed [15:0] ang_raw,
                                 logic signed [15:0] lin_raw);
            drive_result_t r;
            int            ang;
            int            lin;
            int            lim;
            int            w;
            logic          sat;
            r.ack_enable = 1'b0;
            case (op)
                OP_REF: begin
                    if (mode != MODE_HALT) begin
                        ang        = clip_ref(ang_raw);
                        lin        = clip_ref(lin_raw);
                        lim        = int'(rpm_limit);
                        mode       = MODE_CONTROLLED;
                        tick_count = '0;
                        armed      = 1'b1;
                        req_rpm[0] = rpm_of(4 * lin + ang);
                        req_rpm[1] = rpm_of(4 * lin - ang);
                        sat        = 1'b0;
                        for (w = 0; w < 2; w++) begin
                            if (req_rpm[w] > lim) begin
                                app_rpm[w] = lim;
                                sat = 1'b1;
                            end
                            else if (req_rpm[w] < -lim) begin
                                app_rpm[w] = -lim;
                                sat = 1'b1;
                            end
                            else
                                app_rpm[w] = req_rpm[w];
                        end
                        alert = sat;
                    end
                end
                OP_ENABLE: begin
                    if (mode == MODE_HALT) begin
                        mode         = MODE_CONTROLLED;
                        tick_count   = '0;
                        armed        = 1'b1;
                        r.ack_enable = 1'b1;
                    end
                end
                OP_HALT_REL: park_wheels(MODE_HALT);
                default: begin
                    if (armed) begin
                        tick_count = tick_count + 16'd1;
                        if (tick_count >= timeout_ticks)
                            park_wheels(MODE_TIMEOUT);
                    end
                end
            endcase
            r.mode_now   = mode;
            r.left_duty  = duty_of(app_rpm[0]);
            r.right_duty = duty_of(app_rpm[1]);
            r.left_app   = 14'(app_rpm[0]);
            r.right_app  = 14'(app_rpm[1]);
            r.left_req   = 17'(req_rpm[0]);
            r.right_req  = 17'(req_rpm[1]);
            r.alert_on   = alert;
            pending_drive_results.push_back(r);
        endfunction

        function int pending_count();
            return pending_drive_results.size();
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [103:0] word);
            drive_result_t e;
            if (pending_drive_results.size() == 0) begin
                $display("%0t: unexpected result transfer: expected none, actual %h",
                         $time, word);
                errors++;
                return;
            end
            e = pending_drive_results.pop_front();
            compare("mode_now", e.mode_now, word[1:0]);
            compare("left_duty", e.left_duty, word[17:2]);
            compare("right_duty", e.right_duty, word[33:18]);
            compare("left_rpm_applied", e.left_app, $signed(word[47:34]));
            compare("right_rpm_applied", e.right_app, $signed(word[61:48]));
            compare("left_rpm_requested", e.left_req, $signed(word[78:62]));
            compare("right_rpm_requested", e.right_req, $signed(word[95:79]));
            compare("alert_on", e.alert_on, word[96]);
            compare("ack_enable", e.ack_enable, word[97]);
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [15:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    int send_idle_pct = 8;
    int recv_idle_pct = 65;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    drive_result_board board = new();

    differential_drive_mode_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 clk = ~clk;

    // Output side: random back-pressure, plus long hold-offs on request.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HoldOffCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata);
    end

    task automatic send_item(input op_t op, input logic signed [15:0] ang,
                             input logic signed [15:0] lin);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lin, ang};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_event(op, ang, lin);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        board.set_register(idx, value);
    endtask

    task automatic write_config(input logic [15:0] period, input logic [15:0] ticks,
                                input logic [15:0] limit);
        write_reg(CfgPwmPeriod, period);
        write_reg(CfgTimeoutTick, ticks);
        write_reg(CfgRpmLimit, limit);
    endtask

    function automatic logic signed [15:0] random_ref();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 16'(int'($urandom_range(0, 2 * RefLimit)) - RefLimit);
        if (pick < 8)
            return 16'($urandom);
        if (pick < 9)
            return 16'(int'($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sd999;
            3:       return -16'sd999;
            4:       return 16'sd1000;
            default: return -16'sd1000;
        endcase
    endfunction

    // Mostly references and ticks so that timeouts and re-arming recur often.
    task automatic send_random_item();
        int   pick;
        op_t  op;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = OP_REF;
        else if (pick < 75)
            op = OP_TICK;
        else if (pick < 88)
            op = OP_ENABLE;
        else
            op = OP_HALT_REL;
        send_item(op, random_ref(), random_ref());
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input int hold_at,
                             input int pause_at);
        int n;
        send_idle_pct = snd_pct;
        recv_idle_pct <= rcv_pct;
        for (n = 0; n < PhaseItems; n++) begin
            if (n == hold_at)
                hold_requests <= hold_requests + 1;
            if (n == pause_at)
                drain_results();
            send_random_item();
        end
        drain_results();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset configuration: saturation, clamping, floor rounding and the halt path.
        send_item(OP_REF, 16'sd0, 16'sd0);
        send_item(OP_REF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_REF, 16'sh8000, 16'sh8000);
        send_item(OP_REF, -16'sd1, 16'sd0);
        send_item(OP_REF, 16'sd1000, -16'sd1000);
        send_item(OP_REF, -16'sd999, 16'sd999);
        send_item(OP_ENABLE, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0);
        send_item(OP_HALT_REL, 16'sd0, 16'sd0);
        send_item(OP_REF, 16'sd100, 16'sd100);
        send_item(OP_TICK, 16'sd0, 16'sd0);
        send_item(OP_HALT_REL, 16'sd0, 16'sd0);
        send_item(OP_ENABLE, 16'sh5555, 16'shAAAA);
        send_item(OP_REF, 16'sh5555, 16'shAAAA);
        drain_results();

        // Zero timeout expires on the first armed tick; a limit above full
        // scale drives both duty values into their saturation.
        write_config(16'd32767, 16'd0, 16'd8191);
        send_item(OP_REF, 16'sh7FFF, 16'sh7FFF);
        send_item(OP_REF, 16'sh8000, 16'sh8000);
        send_item(OP_TICK, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sd0, 16'sd0);
        send_item(OP_REF, 16'sd0, -16'sd7);
        send_item(OP_ENABLE, 16'sd0, 16'sd0);
        send_item(OP_REF, -16'sd50, 16'sd300);
        drain_results();

        write_config(16'd1, 16'd1, 16'd0);
        send_item(OP_REF, 16'sd123, 16'sd45);
        send_item(OP_TICK, 16'sd0, 16'sd0);
        send_item(OP_HALT_REL, 16'sd0, 16'sd0);
        send_item(OP_ENABLE, 16'sd0, 16'sd0);
        drain_results();

        write_config(16'd1843, 16'd8, 16'd5000);
        run_phase(8, 65, -1, -1);
        write_config(16'd32767, 16'd65535, 16'd6000);
        run_phase(8, 65, 40, -1);
        write_config(16'd1, 16'd1, 16'd0);
        run_phase(65, 8, -1, -1);
        write_config(16'd12000, 16'd20, 16'd3000);
        run_phase(65, 8, -1, 60);
        write_config(16'd32767, 16'd3, 16'd8191);
        run_phase(0, 0, 40, -1);
        write_config(16'($urandom_range(1, 32767)), 16'($urandom_range(2, 30)),
                     16'($urandom_range(0, 6000)));
        run_phase(0, 0, -1, -1);

        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("** differential_drive_mode_controller: PASSED **");
        else
            $display("** differential_drive_mode_controller: FAILED **");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("** differential_drive_mode_controller: FAILED **");
        $finish;
    end
endmodule

>>> files.f
hdl/ddmc_pkg.sv
hdl/ddmc_ctrl.sv
hdl/ddmc_dp.sv
hdl/differential_drive_mode_controller.sv
dv/tb.sv
